// ===== rtl/ttod_pkg.sv =====
// shared constants and types for the trimmed time-of-day clock
`timescale 1ns / 1ps

package ttod_pkg;

   localparam int TICKS_PER_SECOND_DEF = 256;
   localparam int CYCLES_PER_TICK_DEF  = 62500;
   localparam int COMP_INTERVAL_DEF    = 16;

   localparam logic [15:0] INT_MASK  = 16'h7800;
   localparam logic [15:0] FRAC_MASK = 16'h07ff;

   localparam logic [5:0] SECOND_LAST = 6'd59;
   localparam logic [5:0] MINUTE_LAST = 6'd59;
   localparam logic [4:0] HOUR_LAST   = 5'd23;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;
   localparam int TRIM_W     = 16;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_SET_HM  = 2'd1,
      MODE_SET_HMS = 2'd2,
      MODE_PHASE   = 2'd3
   } mode_type;

   // lowest field last
   typedef struct packed {
      logic signed [7:0] phase_shift;
      logic [5:0]        set_seconds;
      logic [5:0]        set_minutes;
      logic [4:0]        set_hours;
   } item_type;

   typedef struct packed {
      logic        second_rolled;
      logic [4:0]  hour_now;
      logic [5:0]  minute_now;
      logic [5:0]  second_now;
      logic [7:0]  jiffy_now;
      logic [15:0] period_top;
   } result_type;

endpackage

// ===== rtl/ttod_trim.sv =====
// compensation interval counter, fraction counter and trimmed timer period
`timescale 1ns / 1ps

module ttod_trim #(
   parameter int CYCLES_PER_TICK = ttod_pkg::CYCLES_PER_TICK_DEF,
   parameter int COMP_INTERVAL   = ttod_pkg::COMP_INTERVAL_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick,
   input  logic [ttod_pkg::TRIM_W-1:0] trim_ppm,
   output logic [15:0]                 period_top
);

   localparam int                  IW            = $clog2(COMP_INTERVAL + 1);
   localparam logic [IW-1:0]       INTERVAL_LAST = IW'(COMP_INTERVAL - 1);
   localparam logic signed [17:0]  TOP_BASE      = 18'(CYCLES_PER_TICK - 1);
   localparam logic signed [17:0]  TOP_MAX       = 18'sd65535;

   logic [IW-1:0]      interval_ff, interval_in;
   logic [15:0]        fraction_ff, fraction_in;
   logic               comp_due;
   logic               neg;
   logic [15:0]        mag;
   logic [15:0]        frac;
   logic [3:0]         ipart;
   logic [15:0]        rise;
   logic               frac_hit;
   logic [4:0]         comp;
   logic signed [17:0] top;

   always_comb begin
      comp_due    = tick && (interval_ff == INTERVAL_LAST);
      interval_in = interval_ff;
      fraction_in = fraction_ff;
      if (tick) begin
         interval_in = comp_due ? '0 : interval_ff + 1'b1;
      end
      if (comp_due) begin
         fraction_in = fraction_ff + 16'd1;
      end

      neg   = trim_ppm[15];
      mag   = neg ? 16'(~trim_ppm + 16'd1) : trim_ppm;
      ipart = 4'((mag & ttod_pkg::INT_MASK) >> 11);
      frac  = mag & ttod_pkg::FRAC_MASK;

      // bit that went from zero to one, against the bit-reversed fraction
      rise     = fraction_in & ~fraction_ff;
      frac_hit = 1'b0;
      for (int i = 0; i < 11; i++) begin
         frac_hit = frac_hit | (frac[10 - i] & rise[i]);
      end

      comp = comp_due ? ({1'b0, ipart} + {4'd0, frac_hit}) : 5'd0;
      top  = neg ? TOP_BASE + $signed({13'd0, comp}) : TOP_BASE - $signed({13'd0, comp});

      if (top < 18'sd0) begin
         period_top = 16'd0;
      end else if (top > TOP_MAX) begin
         period_top = 16'hffff;
      end else begin
         period_top = top[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         fraction_ff <= '0;
      end else begin
         interval_ff <= interval_in;
         fraction_ff <= fraction_in;
      end
   end

endmodule

// ===== rtl/ttod_time.sv =====
// time-of-day registers: jiffy, second, minute and hour cascade, loads and phase shift
`timescale 1ns / 1ps

module ttod_time #(
   parameter int TICKS_PER_SECOND = ttod_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  ttod_pkg::mode_type mode,
   input  ttod_pkg::item_type item,
   output logic [7:0]         jiffy_now,
   output logic [5:0]         second_now,
   output logic [5:0]         minute_now,
   output logic [4:0]         hour_now,
   output logic               second_rolled
);

   localparam int            JW          = $clog2(TICKS_PER_SECOND);
   localparam int            JW1         = JW + 1;
   localparam logic [JW-1:0] JIFFY_LAST  = JW'(TICKS_PER_SECOND - 1);
   localparam logic [JW:0]   JIFFY_WRAP  = JW1'(TICKS_PER_SECOND);

   logic [JW-1:0] jiffy_ff, jiffy_in;
   logic [5:0]    second_ff, second_in;
   logic [5:0]    minute_ff, minute_in;
   logic [4:0]    hour_ff, hour_in;
   logic          rolled;
   logic [JW-1:0] shift_mod [256];
   logic [JW:0]   diff;
   logic [JW:0]   diff_wrap;

   // phase shift reduced modulo the jiffy range, one entry per shift code
   for (genvar g = 0; g < 256; g++) begin : g_shift
      localparam int SHIFT     = (g < 128) ? g : g - 256;
      localparam int SHIFT_MOD = ((SHIFT % TICKS_PER_SECOND) + TICKS_PER_SECOND)
                                 % TICKS_PER_SECOND;
      assign shift_mod[g] = JW'(SHIFT_MOD);
   end

   always_comb begin
      jiffy_in  = jiffy_ff;
      second_in = second_ff;
      minute_in = minute_ff;
      hour_in   = hour_ff;
      rolled    = 1'b0;
      diff      = {1'b0, jiffy_ff} - {1'b0, shift_mod[8'(item.phase_shift)]};
      diff_wrap = diff + JIFFY_WRAP;

      case (mode)
         ttod_pkg::MODE_TICK: begin
            if (jiffy_ff == JIFFY_LAST) begin
               jiffy_in = '0;
               rolled   = 1'b1;
               if (second_ff >= ttod_pkg::SECOND_LAST) begin
                  second_in = '0;
                  if (minute_ff >= ttod_pkg::MINUTE_LAST) begin
                     minute_in = '0;
                     hour_in   = (hour_ff >= ttod_pkg::HOUR_LAST) ? 5'd0 : hour_ff + 5'd1;
                  end else begin
                     minute_in = minute_ff + 6'd1;
                  end
               end else begin
                  second_in = second_ff + 6'd1;
               end
            end else begin
               jiffy_in = jiffy_ff + 1'b1;
            end
         end
         ttod_pkg::MODE_SET_HM: begin
            hour_in   = item.set_hours;
            minute_in = item.set_minutes;
            second_in = '0;
         end
         ttod_pkg::MODE_SET_HMS: begin
            hour_in   = item.set_hours;
            minute_in = item.set_minutes;
            second_in = item.set_seconds;
            jiffy_in  = '0;
         end
         ttod_pkg::MODE_PHASE: begin
            jiffy_in = diff[JW] ? diff_wrap[JW-1:0] : diff[JW-1:0];
         end
         default: begin
            jiffy_in = jiffy_ff;
         end
      endcase

      jiffy_now     = 8'(jiffy_in);
      second_now    = second_in;
      minute_now    = minute_in;
      hour_now      = hour_in;
      second_rolled = rolled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jiffy_ff  <= '0;
         second_ff <= '0;
         minute_ff <= '0;
         hour_ff   <= '0;
      end else if (step) begin
         jiffy_ff  <= jiffy_in;
         second_ff <= second_in;
         minute_ff <= minute_in;
         hour_ff   <= hour_in;
      end
   end

endmodule

// ===== rtl/trimmed_time_of_day_clock.sv =====
// top level of the trimmed time-of-day clock: event stage, trim, time registers, result stage
//
// usage
//   req channel: one event word per handshake; tuser carries the mode (tick, set hours
//   and minutes, set full time, phase shift), tdata the load values and phase shift.
//   rsp channel: exactly one result word per event, in order: next timer top, current
//   jiffy, second, minute, hour and a flag for a completed second.
//   csr port: csr_wr_en writes the signed Q4.11 ppm trim; write it only while idle.
// flow
//   an accepted event is registered in the event stage and then in the result stage,
//   whose word drives rsp; one event per cycle is sustained while rsp_tready stays high.
// reset
//   synchronous; clears time, trim, interval and fraction counters and both stages.
// stall
//   a held result keeps its word; the event stage still takes one more word, then
//   req_tready drops until the result is taken.
//
`timescale 1ns / 1ps

module trimmed_time_of_day_clock #(
   parameter int TICKS_PER_SECOND = ttod_pkg::TICKS_PER_SECOND_DEF,
   parameter int CYCLES_PER_TICK  = ttod_pkg::CYCLES_PER_TICK_DEF,
   parameter int COMP_INTERVAL    = ttod_pkg::COMP_INTERVAL_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // hours[4:0], minutes[10:5], seconds[16:11], phase_shift[24:17], zero fill
   input  logic [ttod_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // period_top[15:0], jiffy[23:16], second[29:24], minute[35:30], hour[40:36],
   // second_rolled[41], zero fill
   output logic [ttod_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [ttod_pkg::TRIM_W-1:0]     csr_wr_data
);

   logic                        stage_valid_ff, stage_valid_in;
   ttod_pkg::mode_type          stage_mode_ff;
   ttod_pkg::item_type          stage_item_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   ttod_pkg::result_type        rsp_data_ff;
   ttod_pkg::result_type        result;
   logic [ttod_pkg::TRIM_W-1:0] trim_ff;
   logic                        req_take;
   logic                        advance;
   logic                        tick;

   assign advance    = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign tick       = advance && (stage_mode_ff == ttod_pkg::MODE_TICK);

   assign stage_valid_in = req_take || (stage_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_tready);

   ttod_trim #(
      .CYCLES_PER_TICK (CYCLES_PER_TICK),
      .COMP_INTERVAL   (COMP_INTERVAL)
   ) u_trim (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .trim_ppm   (trim_ff),
      .period_top (result.period_top)
   );

   ttod_time #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_time (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .mode          (stage_mode_ff),
      .item          (stage_item_ff),
      .jiffy_now     (result.jiffy_now),
      .second_now    (result.second_now),
      .minute_now    (result.minute_now),
      .hour_now      (result.hour_now),
      .second_rolled (result.second_rolled)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         trim_ff        <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            trim_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_mode_ff <= ttod_pkg::mode_type'(req_tuser);
         stage_item_ff <= ttod_pkg::item_type'(req_tdata[24:0]);
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

endmodule

// ===== rtl/ttod_checker.sv =====
// port-level checks for the trimmed time-of-day clock, bound to the top level
`timescale 1ns / 1ps

module ttod_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ttod_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // held result keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // back pressure only comes from a stalled full result stage
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("event side stalled without a stalled result");

   a_roll_jiffy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[41] |-> rsp_tdata[23:16] == 8'd0)
      else $error("second completed with nonzero jiffy");

   a_roll_second: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[41] |-> rsp_tdata[29:24] <= ttod_pkg::SECOND_LAST)
      else $error("second out of range after a completed second");

endmodule

bind trimmed_time_of_day_clock ttod_checker u_ttod_checker (.*);
